>>> hw/rtl/tcab_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcab_pkg
// Shared types, register indexes and helpers for the triangle cover and
// alpha blend pipeline.
// ----------------------------------------------------------------------------
package tcab_pkg;

	// Pixel coordinates are taken modulo 2^COORD_BITS.
	localparam int COORD_BITS  = 12;
	localparam int SLOPE_BITS  = 32;
	localparam int OFFSET_BITS = 40;
	localparam int CFG_BITS    = 40;
	localparam int FRAC_BITS   = 16;

	localparam logic [31:0] PAINT_RESET = 32'h64FF_0000;

	typedef enum logic [2:0] {
		REG_SLOPE_EDGE0  = 3'd0,
		REG_OFFSET_EDGE0 = 3'd1,
		REG_SLOPE_EDGE1  = 3'd2,
		REG_OFFSET_EDGE1 = 3'd3,
		REG_SLOPE_EDGE2  = 3'd4,
		REG_OFFSET_EDGE2 = 3'd5,
		REG_INSIDE_SIDES = 3'd6,
		REG_PAINT_RGBA   = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic [COORD_BITS-1:0] px;
		logic [COORD_BITS-1:0] py;
		logic [7:0]            dst_red;
		logic [7:0]            dst_green;
		logic [7:0]            dst_blue;
		logic [7:0]            dst_alpha;
	} pixel_t;

	typedef struct packed {
		logic [7:0] out_red;
		logic [7:0] out_green;
		logic [7:0] out_blue;
		logic [7:0] out_alpha;
		logic       covered;
	} result_t;

	// Weighted sum paint*a + dest*(255-a); never exceeds 65025.
	function automatic logic [15:0] blend_sum(input logic [7:0] paint,
						  input logic [7:0] dest,
						  input logic [7:0] alpha);
		logic [15:0] p;
		logic [15:0] d;
		p = paint * alpha;
		d = dest * (8'd255 - alpha);
		return p + d;
	endfunction

	// Exact floor(n / 255) for n below 65280 by reciprocal and correction,
	// which covers every weighted sum from blend_sum.
	function automatic logic [7:0] div255(input logic [15:0] n);
		logic [16:0] t;
		t = {1'b0, n} + {9'd0, n[15:8]} + 17'd1;
		return t[15:8];
	endfunction

endpackage

>>> hw/rtl/triangle_cover_alpha_blend.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_cover_alpha_blend
// Tests each pixel against three triangle edges and blends covered pixels
// with a constant paint color.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake                  Payload
//   --------  -------------------------  ------------------------------------
//   pixel     start & !busy              pixel   (px, py, dst RGBA)
//   result    done, one cycle            result  (out RGBA, covered)
//   config    cfg_valid & cfg_ready      cfg_index, cfg_data
//
// One pixel item is accepted per cycle while busy is low, and its result
// appears on done after the edge multiplier stage, the line compare stage
// and the divide-by-255 stage.
// After reset releases, busy drops and cfg_ready rises on the next clock.
// The receiver cannot stall, so the pipeline simply advances every cycle.
// Configuration registers take their reset values on arst_n and should only
// be written while no item is in flight.
//
module triangle_cover_alpha_blend (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  tcab_pkg::pixel_t              pixel,
	output logic                          done,
	output tcab_pkg::result_t             result,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [2:0]                    cfg_index,
	input  logic [tcab_pkg::CFG_BITS-1:0] cfg_data
);
	import tcab_pkg::*;

	// Configuration registers.
	logic signed [SLOPE_BITS-1:0]  slope_q  [3];
	logic signed [OFFSET_BITS-1:0] offset_q [3];
	logic [2:0]                    sides_q;
	logic [31:0]                   paint_q;
	logic                          ready_q;

	// Pipeline state.
	logic       v_s1, v_s2, v_s3;
	pixel_t     pix_s1, pix_s2;
	logic [15:0] sum_r_s2, sum_g_s2, sum_b_s2;
	logic [2:0] above_s2;
	result_t    res_s3;
	logic       accept;
	logic       covered;
	logic [7:0] alpha;

	// The block can take an item every cycle once out of reset.
	assign busy      = ~ready_q;
	assign cfg_ready = ready_q;
	assign accept    = start & ~busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ready_q <= 1'b0;
		end else begin
			ready_q <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 3; k++) begin
				slope_q[k]  <= '0;
				offset_q[k] <= '0;
			end
			sides_q <= '0;
			paint_q <= PAINT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_SLOPE_EDGE0:  slope_q[0]  <= cfg_data[SLOPE_BITS-1:0];
				REG_OFFSET_EDGE0: offset_q[0] <= cfg_data[OFFSET_BITS-1:0];
				REG_SLOPE_EDGE1:  slope_q[1]  <= cfg_data[SLOPE_BITS-1:0];
				REG_OFFSET_EDGE1: offset_q[1] <= cfg_data[OFFSET_BITS-1:0];
				REG_SLOPE_EDGE2:  slope_q[2]  <= cfg_data[SLOPE_BITS-1:0];
				REG_OFFSET_EDGE2: offset_q[2] <= cfg_data[OFFSET_BITS-1:0];
				REG_INSIDE_SIDES: sides_q     <= cfg_data[2:0];
				REG_PAINT_RGBA:   paint_q     <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	// Valid bits travel alongside the data through all three stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Each edge unit produces its answer in step with stage two.
	for (genvar k = 0; k < 3; k++) begin : g_edge
		tcab_edge u_edge (
			.clk      (clk),
			.x        (pixel.px),
			.y        (pixel.py),
			.slope    (slope_q[k]),
			.offset   (offset_q[k]),
			.above_s2 (above_s2[k])
		);
	end

	assign alpha = paint_q[31:24];

	// Stage one captures the pixel; stage two holds the weighted blend sums.
	always_ff @(posedge clk) begin
		pix_s1   <= pixel;
		pix_s2   <= pix_s1;
		sum_r_s2 <= blend_sum(paint_q[7:0],   pix_s1.dst_red,   alpha);
		sum_g_s2 <= blend_sum(paint_q[15:8],  pix_s1.dst_green, alpha);
		sum_b_s2 <= blend_sum(paint_q[23:16], pix_s1.dst_blue,  alpha);
	end

	// The pixel is inside when every edge answer matches its side bit.
	assign covered = (above_s2 == sides_q);

	// Stage three divides by 255 and picks blended or original color.
	always_ff @(posedge clk) begin
		res_s3.out_red   <= covered ? div255(sum_r_s2) : pix_s2.dst_red;
		res_s3.out_green <= covered ? div255(sum_g_s2) : pix_s2.dst_green;
		res_s3.out_blue  <= covered ? div255(sum_b_s2) : pix_s2.dst_blue;
		res_s3.out_alpha <= pix_s2.dst_alpha;
		res_s3.covered   <= covered;
	end

	assign done   = v_s3;
	assign result = res_s3;

endmodule

>>> hw/rtl/tcab_edge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcab_edge
// Two-stage edge test: multiplies slope by x, then compares y against the
// line value. Answers whether the pixel lies on or above the edge.
// ----------------------------------------------------------------------------
module tcab_edge (
	input  logic                                 clk,
	input  logic [tcab_pkg::COORD_BITS-1:0]      x,
	input  logic [tcab_pkg::COORD_BITS-1:0]      y,
	input  logic signed [tcab_pkg::SLOPE_BITS-1:0]  slope,
	input  logic signed [tcab_pkg::OFFSET_BITS-1:0] offset,
	output logic                                 above_s2
);
	import tcab_pkg::*;

	localparam int PROD_W = SLOPE_BITS + COORD_BITS + 1;
	localparam int SUM_W  = PROD_W + 1;

	logic signed [PROD_W-1:0]   prod_s1;
	logic [COORD_BITS-1:0]      y_s1;
	logic signed [SUM_W-1:0]    line_val;
	logic signed [SUM_W-1:0]    y_fix;

	always_ff @(posedge clk) begin
		prod_s1 <= slope * $signed({1'b0, x});
		y_s1    <= y;
	end

	assign line_val = SUM_W'(prod_s1) + SUM_W'(offset);
	assign y_fix    = $signed(SUM_W'({y_s1, {FRAC_BITS{1'b0}}}));

	always_ff @(posedge clk) begin
		above_s2 <= (y_fix >= line_val);
	end

endmodule

>>> hw/rtl/tcab_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcab_check
// Port-level checks of result timing and pass-through of the pixel bytes.
// ----------------------------------------------------------------------------
module tcab_check (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input tcab_pkg::pixel_t  pixel,
	input logic              done,
	input tcab_pkg::result_t result
);
	import tcab_pkg::*;

	// Every accepted item yields exactly one result strobe on done, and no strobe comes without one.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done == $past(start && !busy, 3))
		else $error("result strobe does not follow acceptance by three cycles");

	// Alpha always passes through from the matching input item.
	a_alpha: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> result.out_alpha == $past(pixel.dst_alpha, 3))
		else $error("alpha byte not passed through");

	// An uncovered pixel leaves its colors unchanged.
	a_outside: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.covered) |->
			(result.out_red == $past(pixel.dst_red, 3) &&
			 result.out_green == $past(pixel.dst_green, 3) &&
			 result.out_blue == $past(pixel.dst_blue, 3)))
		else $error("uncovered pixel color altered");

endmodule

bind triangle_cover_alpha_blend tcab_check u_tcab_check (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.pixel  (pixel),
	.done   (done),
	.result (result)
);
